FILE: rtl/core/slip_deframer_with_header_macros.svh
// Assertion macros used by the SLIP deframer core
`ifndef SLIP_DEFRAMER_WITH_HEADER_MACROS_SVH
`define SLIP_DEFRAMER_WITH_HEADER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SDH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled during reset
`define SDH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SDH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define SDH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/sdh_pkg.sv
// Package: constants and types of the SLIP deframer
`timescale 1ns / 1ps
package sdh_pkg;

   // SLIP special characters
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   localparam int          LEN_W         = 17;
   localparam logic [16:0] HEADER_LEN    = 17'd8;
   localparam logic [15:0] MAX_LEN_RESET = 16'(20 * 1024);

   // register file
   localparam int         CSR_ADDR_W           = 3;
   localparam logic       REG_MAX_FRAME_LENGTH = 1'b0;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_MESSAGE  = 3'd0,
      STATUS_ACK      = 3'd1,
      STATUS_SHORT    = 3'd2,
      STATUS_ACK_BODY = 3'd3,
      STATUS_DROPPED  = 3'd4
   } sdh_status_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        payload;
      sdh_status_type    status;
      logic [31:0]       id;
      logic [15:0]       mtype;
      logic [15:0]       flags;
      logic [LEN_W-1:0]  length;
   } sdh_result_type;

endpackage

FILE: rtl/core/slip_deframer_with_header.sv
// A result is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register sets the figure,
// and a new byte is taken whenever that register is empty or being emptied.
// Reset (synchronous, active high): clears escape and error flags, frame count
// and header, empties the result register and sets the length limit to 20480.
`timescale 1ns / 1ps
module slip_deframer_with_header (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic [7:0]                     rsp_payload_byte,
   output logic [2:0]                     rsp_frame_status,
   output logic [31:0]                    rsp_message_id,
   output logic [15:0]                    rsp_message_type,
   output logic [15:0]                    rsp_message_flags,
   output logic [16:0]                    rsp_frame_length,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sdh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   logic                    accept;
   logic                    emit;
   logic [15:0]             max_len;
   sdh_pkg::sdh_result_type result;
   sdh_pkg::sdh_result_type held;

   assign accept = req_valid && !req_stall;

   sdh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .max_len (max_len)
   );

   sdh_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .max_len (max_len),
      .emit    (emit),
      .result  (result)
   );

   sdh_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .emit      (emit),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .req_stall (req_stall),
      .held      (held)
   );

   // result fields
   assign rsp_result_kind   = held.kind;
   assign rsp_payload_byte  = held.payload;
   assign rsp_frame_status  = held.status;
   assign rsp_message_id    = held.id;
   assign rsp_message_type  = held.mtype;
   assign rsp_message_flags = held.flags;
   assign rsp_frame_length  = held.length;

endmodule

FILE: rtl/core/sdh_csr.sv
// Register file: APB-style access to the frame length limit
`timescale 1ns / 1ps
module sdh_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sdh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic [15:0]                    max_len
);
   logic [15:0] max_len_ff;
   logic [15:0] max_len_in;
   logic        reg_hit;

   // word index sits above the byte offset
   assign reg_hit = (paddr[2] == sdh_pkg::REG_MAX_FRAME_LENGTH);
   assign pready  = 1'b1;

   // write on the access phase
   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && reg_hit) begin
         max_len_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= sdh_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // read back
   assign prdata  = reg_hit ? {16'd0, max_len_ff} : 32'd0;
   assign max_len = max_len_ff;

endmodule

FILE: rtl/core/sdh_core.sv
// Deframer core: unescaping, header capture, length count and frame status
`timescale 1ns / 1ps
`include "slip_deframer_with_header_macros.svh"
module sdh_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic [15:0]            max_len,
   output logic                   emit,
   output sdh_pkg::sdh_result_type result
);
   logic                          esc_ff, esc_in;
   logic                          err_ff, err_in;
   logic [sdh_pkg::LEN_W-1:0]     count_ff, count_in;
   logic [63:0]                   header_ff, header_in;

   logic                          over;
   logic                          add_en;
   logic [7:0]                    add_val;
   logic [15:0]                   flags;

   assign over  = (count_ff > {1'b0, max_len});
   assign flags = header_ff[63:48];

   // per-byte decode
   always_comb begin
      esc_in    = esc_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      header_in = header_ff;
      emit      = 1'b0;
      result    = '0;
      add_en    = 1'b0;
      add_val   = rx_byte;

      if (rx_byte == sdh_pkg::SLIP_END) begin
         // frame end: report and clear
         emit          = 1'b1;
         result.kind   = sdh_pkg::KIND_REPORT;
         result.length = count_ff;
         if (err_ff || over) begin
            result.status = sdh_pkg::STATUS_DROPPED;
         end else if (count_ff < sdh_pkg::HEADER_LEN) begin
            result.status = sdh_pkg::STATUS_SHORT;
         end else begin
            if (flags[0]) begin
               result.status = (count_ff == sdh_pkg::HEADER_LEN) ?
                               sdh_pkg::STATUS_ACK : sdh_pkg::STATUS_ACK_BODY;
            end else begin
               result.status = sdh_pkg::STATUS_MESSAGE;
            end
            result.id    = header_ff[31:0];
            result.mtype = header_ff[47:32];
            result.flags = flags;
         end
         esc_in    = 1'b0;
         err_in    = 1'b0;
         count_in  = '0;
         header_in = '0;
      end else if (over) begin
         // past the limit: discard
         err_in = 1'b1;
      end else if (esc_ff) begin
         esc_in = 1'b0;
         if (rx_byte == sdh_pkg::SLIP_ESC_END) begin
            add_en  = 1'b1;
            add_val = sdh_pkg::SLIP_END;
         end else if (rx_byte == sdh_pkg::SLIP_ESC_ESC) begin
            add_en  = 1'b1;
            add_val = sdh_pkg::SLIP_ESC;
         end else begin
            err_in = 1'b1;
         end
      end else if (rx_byte == sdh_pkg::SLIP_ESC) begin
         esc_in = 1'b1;
      end else begin
         add_en = 1'b1;
      end

      // store an unescaped byte: header slot or payload
      if (add_en) begin
         if (count_ff < sdh_pkg::HEADER_LEN) begin
            for (int i = 0; i < 8; i++) begin
               if (count_ff[2:0] == 3'(i)) begin
                  header_in[i*8 +: 8] = add_val;
               end
            end
         end else if (!err_ff) begin
            emit           = 1'b1;
            result.kind    = sdh_pkg::KIND_PAYLOAD;
            result.payload = add_val;
            result.length  = count_ff + 17'd1;
         end
         count_in = count_ff + 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= 1'b0;
         err_ff    <= 1'b0;
         count_ff  <= '0;
         header_ff <= '0;
      end else if (accept) begin
         esc_ff    <= esc_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
         header_ff <= header_in;
      end
   end

   `SDH_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= 17'h10000, "count over 65536")
   `SDH_ASSERT_NEXT(a_end_clears, clock, reset, accept && rx_byte == sdh_pkg::SLIP_END, !esc_ff && !err_ff && count_ff == '0, "frame end did not clear state")
   `SDH_ASSERT_IMPLY(a_payload_len, clock, reset, emit && result.kind == sdh_pkg::KIND_PAYLOAD, result.length > sdh_pkg::HEADER_LEN && !err_ff, "payload inside header or after error")
   `SDH_ASSERT_IMPLY(a_drop_no_hdr, clock, reset, emit && (result.status == sdh_pkg::STATUS_DROPPED || result.status == sdh_pkg::STATUS_SHORT), result.id == '0 && result.flags == '0, "header given in drop or short report")

endmodule

FILE: rtl/core/sdh_out_reg.sv
// Result register: holds one result transaction until the sink takes it
`timescale 1ns / 1ps
module sdh_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    emit,
   input  sdh_pkg::sdh_result_type result,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    req_stall,
   output sdh_pkg::sdh_result_type held
);
   logic                    valid_ff, valid_in;
   sdh_pkg::sdh_result_type data_ff;

   // upstream stalls only when a held result is not taken
   assign req_stall = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = emit;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule
